[rtl/plr_pkg.sv]
// ----------------------------------------------------------------------------
// plr_pkg: shared types and constants for the piecewise-linear lookup
// Holds the command and result beat structures and the sequencer states.
// ----------------------------------------------------------------------------
package plr_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int RATIO_BITS  = 31;
	localparam int LANES       = 4;
	localparam int CFG_WIDTH   = 9;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic                          action;
		logic [7:0]                    entry_index;
		logic signed [VALUE_WIDTH-1:0] breakpoint;
		logic signed [VALUE_WIDTH-1:0] area_value;
		logic signed [VALUE_WIDTH-1:0] min_volume_value;
		logic signed [VALUE_WIDTH-1:0] max_volume_value;
		logic signed [VALUE_WIDTH-1:0] gradient_value;
		logic signed [VALUE_WIDTH-1:0] query_value;
	} in_t;

	typedef struct packed {
		logic                          found;
		logic signed [VALUE_WIDTH-1:0] area_out;
		logic signed [VALUE_WIDTH-1:0] min_volume_out;
		logic signed [VALUE_WIDTH-1:0] max_volume_out;
		logic signed [VALUE_WIDTH-1:0] gradient_out;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_RDA,
		ST_RDB,
		ST_RDC,
		ST_MUL,
		ST_ADD
	} state_t;

endpackage

[rtl/plr_ram.sv]
// ----------------------------------------------------------------------------
// plr_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module plr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/piecewise_linear_lookup.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_lookup: breakpoint table with linear interpolation
// Loads write one breakpoint and its four samples; queries search the
// table and interpolate the four samples at the query point.
// ----------------------------------------------------------------------------
// A load writes its entry on acceptance and busy stays low, so loads may follow each other.
// A query with n entries in use (at least two) that finds a segment scans the n breakpoints,
// runs a bit-serial divide for the 31-bit ratio, reads the two bounding sample words over the
// RDA, RDB and RDC states and takes the four samples in turn through MUL and ADD on a shared
// multiplier. A miss frees the block once the scan ends and its result beat has gone out;
// the receiver cannot stall the beat.
// Reset clears the sequencer and the entry count; table contents stay undefined.
module piecewise_linear_lookup #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  plr_pkg::in_t                     cmd,
	output logic                             busy,
	output logic                             done,
	output plr_pkg::out_t                    result,
	input  logic                             cfg_we,
	input  logic [plr_pkg::CFG_WIDTH-1:0]    cfg_wdata
);

	import plr_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int VW = VALUE_WIDTH;
	localparam int DW = VW + 1;               // width of a difference
	localparam int PW = DW + RATIO_BITS;      // width of a product
	localparam int SW = LANES * VW;           // packed sample word

	state_t state_q, state_d;

	logic [CFG_WIDTH-1:0] cfg_q;
	logic [CW-1:0]        n_q;
	logic [CW-1:0]        rd_cnt_q;
	logic                 vld_s1;
	logic [AW-1:0]        idx_s1;

	logic signed [VW-1:0] query_q, prev_q, x0_q, x1_q;
	logic [AW-1:0]        seg_q;
	logic                 hit_q;

	logic [DW-1:0]          rem_q, den_q;
	logic [RATIO_BITS-1:0]  ratio_q;
	logic [4:0]             bit_cnt_q;

	logic [SW-1:0]  v0_q, v1_q;
	logic [1:0]     lane_q;
	logic [PW-1:0]  prod_q;
	logic           neg_q;
	logic [SW-1:0]  res_q;
	logic           found_q;
	logic           done_q;

	// Memory ports.
	logic                 ld_we;
	logic [AW-1:0]        ld_addr;
	logic [AW+7:0]        idx_ext;
	logic [AW-1:0]        bp_raddr, smp_raddr;
	logic [VW-1:0]        bp_rdata;
	logic [SW-1:0]        smp_rdata, smp_wdata;
	logic                 accept, issue;

	assign accept  = start && !busy;
	assign idx_ext = {{AW{1'b0}}, cmd.entry_index};
	assign ld_addr = idx_ext[AW-1:0];
	// Loads beyond the table are dropped.
	assign ld_we   = accept && (cmd.action == ACT_LOAD) &&
	                 (32'(cmd.entry_index) < TABLE_DEPTH);
	assign smp_wdata = {cmd.area_value, cmd.min_volume_value,
	                    cmd.max_volume_value, cmd.gradient_value};

	assign issue    = (state_q == ST_SCAN) && (rd_cnt_q < n_q);
	assign bp_raddr = rd_cnt_q[AW-1:0];

	plr_ram #(.WIDTH(VW), .DEPTH(TABLE_DEPTH)) u_bp_ram (
		.clk   (clk),
		.we    (ld_we),
		.waddr (ld_addr),
		.wdata (cmd.breakpoint),
		.raddr (bp_raddr),
		.rdata (bp_rdata)
	);

	plr_ram #(.WIDTH(SW), .DEPTH(TABLE_DEPTH)) u_smp_ram (
		.clk   (clk),
		.we    (ld_we),
		.waddr (ld_addr),
		.wdata (smp_wdata),
		.raddr (smp_raddr),
		.rdata (smp_rdata)
	);

	// Segment test on the breakpoint that has just come back from memory,
	// against the one read in the cycle before.
	logic signed [VW-1:0] bp_s;
	logic                 seg_hit;
	assign bp_s    = $signed(bp_rdata);
	assign seg_hit = vld_s1 && (idx_s1 != '0) && (query_q >= prev_q) && (query_q < bp_s);

	// One restoring division step: the remainder always stays below den.
	logic [DW:0] rem2;
	logic        rem_ge;
	assign rem2   = {rem_q, 1'b0};
	assign rem_ge = rem2 >= {1'b0, den_q};

	// Lane operands for the shared multiplier; lane 0 is the area sample,
	// which sits in the top slice of the packed word.
	logic [1:0]           lane_sel;
	logic signed [VW-1:0] v0_l, v1_l;
	logic signed [DW-1:0] dv;
	logic [DW-1:0]        mag;
	logic [PW:0]          prod_up;
	logic [DW:0]          delta_abs;
	logic signed [DW+1:0] sum;

	assign lane_sel = 2'(LANES - 1) - lane_q;
	assign v0_l     = $signed(v0_q[lane_sel*VW +: VW]);
	assign v1_l     = $signed(v1_q[lane_sel*VW +: VW]);
	assign dv       = DW'(v1_l) - DW'(v0_l);
	assign mag      = dv[DW-1] ? DW'(-dv) : DW'(dv);

	// Negative steps round the magnitude up so that the total floors.
	assign prod_up   = {1'b0, prod_q} + (PW+1)'((64'd1 << RATIO_BITS) - 64'd1);
	assign delta_abs = neg_q ? (DW+1)'(prod_up >> RATIO_BITS)
	                         : (DW+1)'(prod_q >> RATIO_BITS);
	assign sum       = neg_q ? ((DW+2)'(v0_l) - $signed({1'b0, delta_abs}))
	                         : ((DW+2)'(v0_l) + $signed({1'b0, delta_abs}));

	// Sequencer.
	always_comb begin
		state_d   = state_q;
		smp_raddr = seg_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd.action == ACT_QUERY) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!issue && !vld_s1) begin
					state_d = (hit_q || seg_hit) ? ST_DIV : ST_IDLE;
				end
			end
			ST_DIV: begin
				if (bit_cnt_q == 5'(RATIO_BITS - 1)) begin
					state_d = ST_RDA;
				end
			end
			ST_RDA: begin
				state_d = ST_RDB;
			end
			ST_RDB: begin
				smp_raddr = seg_q + AW'(1);
				state_d   = ST_RDC;
			end
			ST_RDC: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				state_d = (lane_q == 2'(LANES - 1)) ? ST_IDLE : ST_MUL;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE) || done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cfg_q   <= '0;
			done_q  <= 1'b0;
			vld_s1  <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			vld_s1 <= issue;
			done_q <= 1'b0;
			if (state_q == ST_IDLE && state_d == ST_SCAN) begin
				hit_q <= 1'b0;
			end else if (seg_hit) begin
				hit_q <= 1'b1;
			end
			// The result beat goes out once the scan misses or the last lane is done.
			if ((state_q == ST_SCAN && state_d == ST_IDLE) ||
			    (state_q == ST_ADD && state_d == ST_IDLE)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= bp_raddr;
		unique case (state_q)
			ST_IDLE: begin
				query_q  <= cmd.query_value;
				rd_cnt_q <= '0;
				lane_q   <= '0;
				if (32'(cfg_q) > TABLE_DEPTH) begin
					n_q <= CW'(TABLE_DEPTH);
				end else begin
					n_q <= CW'(cfg_q);
				end
			end
			ST_SCAN: begin
				if (issue) begin
					rd_cnt_q <= rd_cnt_q + CW'(1);
				end
				if (vld_s1) begin
					prev_q <= bp_s;
				end
				if (seg_hit) begin
					seg_q <= idx_s1 - AW'(1);
					x0_q  <= prev_q;
					x1_q  <= bp_s;
				end
				found_q <= hit_q || seg_hit;
				res_q   <= '0;
				// Prepare the divide from the last matching segment.
				rem_q     <= DW'(query_q) - DW'(x0_q);
				den_q     <= DW'(x1_q) - DW'(x0_q);
				bit_cnt_q <= '0;
				if (seg_hit) begin
					rem_q <= DW'(query_q) - DW'(prev_q);
					den_q <= DW'(bp_s) - DW'(prev_q);
				end
			end
			ST_DIV: begin
				rem_q     <= rem_ge ? DW'(rem2 - {1'b0, den_q}) : DW'(rem2);
				ratio_q   <= {ratio_q[RATIO_BITS-2:0], rem_ge};
				bit_cnt_q <= bit_cnt_q + 5'd1;
			end
			ST_RDA: begin
			end
			ST_RDB: begin
				v0_q <= smp_rdata;
			end
			ST_RDC: begin
				v1_q <= smp_rdata;
			end
			ST_MUL: begin
				prod_q <= PW'(mag * ratio_q);
				neg_q  <= dv[DW-1];
			end
			ST_ADD: begin
				res_q[lane_sel*VW +: VW] <= sum[VW-1:0];
				lane_q <= lane_q + 2'd1;
			end
			default: begin
			end
		endcase
	end

	assign done                  = done_q;
	assign result.found          = found_q;
	assign result.area_out       = res_q[3*VW +: VW];
	assign result.min_volume_out = res_q[2*VW +: VW];
	assign result.max_volume_out = res_q[1*VW +: VW];
	assign result.gradient_out   = res_q[0 +: VW];

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the piecewise-linear lookup
// Loads breakpoint tables, fires queries with random pacing and checks every
// result beat against a bit-accurate interpolation model held in a scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import plr_pkg::*;

	localparam int DEPTH      = 256;
	localparam int IDLE_LIMIT = 2000;
	localparam int ITEM_GOAL  = 1200;

	// Scoreboard: keeps its own copy of the table and the entry count, works out
	// the expected result of every accepted query and checks result beats in order.
	class lookup_scoreboard;
		in_t  table_mem [DEPTH];
		int   count_in_use;
		out_t pending_results [$];
		int   failures;

		function new();
			count_in_use = 0;
			failures = 0;
		endfunction

		function void set_count(int value);
			count_in_use = value;
		endfunction

		// v0 + floor((v1 - v0) * ratio / 2^31), rounding towards minus infinity.
		function longint blend(longint v0, longint v1, bit [63:0] ratio);
			longint    dv;
			bit [63:0] mag;
			bit [63:0] prod;
			longint    delta;
			dv = v1 - v0;
			mag = (dv < 0) ? -dv : dv;
			prod = mag * ratio;
			if (dv >= 0) begin
				delta = longint'(prod >> RATIO_BITS);
			end else begin
				delta = -longint'((prod + ((64'd1 << RATIO_BITS) - 1)) >> RATIO_BITS);
			end
			return v0 + delta;
		endfunction

		function void note_input(in_t beat);
			int        limit;
			longint    q, x0, x1;
			bit [63:0] num, den, ratio;
			out_t      expected;
			if (beat.action == ACT_LOAD) begin
				table_mem[beat.entry_index] = beat;
				return;
			end
			limit = (count_in_use > DEPTH) ? DEPTH : count_in_use;
			expected = '0;
			q = beat.query_value;
			// Every matching segment overwrites the last, so the final match wins.
			for (int i = 0; i + 1 < limit; i++) begin
				x0 = table_mem[i].breakpoint;
				x1 = table_mem[i + 1].breakpoint;
				if (q >= x0 && q < x1) begin
					num = q - x0;
					den = x1 - x0;
					ratio = (num << RATIO_BITS) / den;
					expected.found = 1'b1;
					expected.area_out = VALUE_WIDTH'(blend(table_mem[i].area_value,
						table_mem[i + 1].area_value, ratio));
					expected.min_volume_out = VALUE_WIDTH'(blend(table_mem[i].min_volume_value,
						table_mem[i + 1].min_volume_value, ratio));
					expected.max_volume_out = VALUE_WIDTH'(blend(table_mem[i].max_volume_value,
						table_mem[i + 1].max_volume_value, ratio));
					expected.gradient_out = VALUE_WIDTH'(blend(table_mem[i].gradient_value,
						table_mem[i + 1].gradient_value, ratio));
				end
			end
			pending_results.push_back(expected);
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (pending_results.size() == 0) begin
				$error("result beat with no query outstanding");
				failures++;
				return;
			end
			want = pending_results.pop_front();
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				failures++;
			end
			if (got.area_out !== want.area_out) begin
				$error("area_out: expected %0d, got %0d", want.area_out, got.area_out);
				failures++;
			end
			if (got.min_volume_out !== want.min_volume_out) begin
				$error("min_volume_out: expected %0d, got %0d",
					want.min_volume_out, got.min_volume_out);
				failures++;
			end
			if (got.max_volume_out !== want.max_volume_out) begin
				$error("max_volume_out: expected %0d, got %0d",
					want.max_volume_out, got.max_volume_out);
				failures++;
			end
			if (got.gradient_out !== want.gradient_out) begin
				$error("gradient_out: expected %0d, got %0d",
					want.gradient_out, got.gradient_out);
				failures++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	in_t                  cmd = '0;
	logic                 busy;
	logic                 done;
	out_t                 result;
	logic                 cfg_we = 1'b0;
	logic [CFG_WIDTH-1:0] cfg_wdata = '0;

	lookup_scoreboard sb = new();
	int items_sent = 0;
	int quiet_cycles = 0;
	bit steady_pace;             // when set, the sender never leaves a gap
	int breakpoints [$];         // breakpoints of entries 0 .. n-1 as loaded

	piecewise_linear_lookup uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result beats cannot be held off, so every done cycle is checked at once.
	// The watchdog restarts whenever a command or a result beat moves.
	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_result(result);
		end
		if (arst_n && ((start && !busy) || done)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Sends one command beat. Start stays high across back-to-back beats and is
	// lowered when a gap is drawn or the bench drains, so it never toggles within one step.
	task automatic send_beat(in_t beat);
		int gap;
		gap = steady_pace ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= beat;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sb.note_input(beat);
		items_sent++;
	endtask

	// Waits until the block is idle: every result is in and a load that may
	// still be settling has had time to finish.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_count(int value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= CFG_WIDTH'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_count(value);
	endtask

	function automatic int random_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $signed($urandom_range(0, 32'h0003_ffff)) - 32'h0002_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic in_t load_beat(int idx, int bp);
		in_t b;
		b.action = ACT_LOAD;
		b.entry_index = 8'(idx);
		b.breakpoint = bp;
		b.area_value = random_value();
		b.min_volume_value = random_value();
		b.max_volume_value = random_value();
		b.gradient_value = random_value();
		b.query_value = $urandom;   // ignored by a load
		return b;
	endfunction

	function automatic in_t query_beat(int q);
		in_t b;
		b = load_beat($urandom_range(0, 255), $urandom);   // payload ignored by a query
		b.action = ACT_QUERY;
		b.query_value = q;
		return b;
	endfunction

	task automatic load_entry(int idx, int bp, int area, int vmin, int vmax, int grad);
		in_t b;
		b = load_beat(idx, bp);
		b.area_value = area;
		b.min_volume_value = vmin;
		b.max_volume_value = vmax;
		b.gradient_value = grad;
		send_beat(b);
	endtask

	// Picks a query point: mostly inside a segment, sometimes exactly on a
	// breakpoint, and otherwise anywhere in the full signed range.
	function automatic int pick_query();
		int        i;
		longint    span;
		bit [63:0] offset;
		if (breakpoints.size() >= 2 && $urandom_range(0, 99) < 60) begin
			i = $urandom_range(0, breakpoints.size() - 2);
			span = longint'(breakpoints[i + 1]) - longint'(breakpoints[i]);
			if (span <= 0) return breakpoints[i];
			offset = {$urandom, $urandom};
			return 32'(longint'(breakpoints[i]) + longint'(offset % span));
		end
		if (breakpoints.size() > 0 && $urandom_range(0, 99) < 40) begin
			return breakpoints[$urandom_range(0, breakpoints.size() - 1)];
		end
		return random_value();
	endfunction

	// One random phase: set the entry count, fill every entry that a query will
	// search, then run queries with the odd load to an unsearched entry mixed in.
	task automatic run_phase(int count, int queries);
		int filled;
		int bp;
		drain();
		write_count(count);
		steady_pace = ($urandom_range(0, 2) == 0);
		filled = (count > DEPTH) ? DEPTH : count;
		breakpoints.delete();
		for (int i = 0; i < filled; i++) begin
			bp = ($urandom_range(0, 3) == 0) ? $urandom : random_value();
			breakpoints.push_back(bp);
		end
		// Most tables are sorted, so queries get past the scan; some are left
		// raw, and a few gain repeated breakpoints that give empty segments.
		if ($urandom_range(0, 9) != 0) begin
			breakpoints.sort();
		end
		if (filled >= 2 && $urandom_range(0, 4) == 0) begin
			bp = $urandom_range(1, filled - 1);
			breakpoints[bp] = breakpoints[bp - 1];
		end
		for (int i = 0; i < filled; i++) begin
			send_beat(load_beat(i, breakpoints[i]));
		end
		for (int k = 0; k < queries; k++) begin
			if (filled < DEPTH && $urandom_range(0, 9) == 0) begin
				send_beat(load_beat($urandom_range(filled, DEPTH - 1), $urandom));
			end else begin
				send_beat(query_beat(pick_query()));
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		steady_pace = 1'b0;

		// Directed: an empty table and a single entry can never match.
		write_count(0);
		send_beat(query_beat(0));
		write_count(1);
		load_entry(0, 0, 1, 2, 3, 4);
		send_beat(query_beat(0));

		// One segment spanning the whole signed range, samples at both extremes.
		write_count(2);
		load_entry(0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
		load_entry(1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, -1);
		send_beat(query_beat(32'h8000_0000));
		send_beat(query_beat(0));
		send_beat(query_beat(32'h7fff_fffe));
		send_beat(query_beat(32'h7fff_ffff));   // upper end is open, so no match

		// Two overlapping segments with different samples: the later one wins.
		write_count(4);
		load_entry(2, 32'h8000_0000, 100, -100, 7, 32'h7fff_ffff);
		load_entry(3, 32'h7fff_ffff, -100, 100, 7, 32'h8000_0000);
		send_beat(query_beat(5));
		send_beat(query_beat(32'h8000_0000));

		// A full table, then a count beyond the depth, which saturates.
		run_phase(DEPTH, 30);
		run_phase(511, 20);

		while (items_sent < ITEM_GOAL) begin
			case ($urandom_range(0, 9))
				0: run_phase($urandom_range(0, 1), 8);
				1: run_phase($urandom_range(17, 64), 25);
				default: run_phase($urandom_range(2, 16), $urandom_range(15, 40));
			endcase
		end

		drain();
		repeat (60) @(posedge clk);
		if (sb.failures == 0 && sb.pending_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[files.f]
rtl/plr_pkg.sv
rtl/plr_ram.sv
rtl/piecewise_linear_lookup.sv
test/tb_top.sv
